// ----- design/mhd_gravity_rotation_source_assert.svh -----
// Assertion macros shared by the gravity and rotation source block
`ifndef MHD_GRAVITY_ROTATION_SOURCE_ASSERT_SVH
`define MHD_GRAVITY_ROTATION_SOURCE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MGRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MGRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mgrs_pkg.sv -----
// Types, constants and fixed-point helpers for the gravity and rotation source block
package mgrs_pkg;

  // register map, word index into the APB space
  typedef enum logic [2:0] {
    REG_GRAVITY_ON    = 3'd0,
    REG_ROTATION_ON   = 3'd1,
    REG_MIXED_CORR    = 3'd2,
    REG_PHI_DAMPING   = 3'd3,
    REG_GRAVITY_COEFF = 3'd4,
    REG_OMEGA_RATE    = 3'd5,
    REG_THREE_D       = 3'd6
  } reg_idx_e;

  // pipeline depth of the iterative units
  localparam int SqrtSteps  = 32;                     // one root bit per stage
  localparam int GdivSteps  = 47;                     // gravity magnitude quotient bits
  localparam int UdivSteps  = 17;                     // unit vector quotient bits
  localparam int MidStages  = SqrtSteps + UdivSteps;  // sqrt then unit divide
  localparam int LateStages = 7;

  localparam logic [47:0] GCap = 48'h8000_0000_0000;
  localparam logic signed [63:0] QMax = 64'sd2147483647;
  localparam logic signed [63:0] QMin = -64'sd2147483648;

  // one solution point as it travels down the pipe
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [31:0]      rho;
    logic [31:0]      phi;
    logic [15:0]      idx;
    logic             pert;
  } item_t;

  // radius and divide stages
  typedef struct packed {
    logic             valid;
    item_t            it;
    logic [63:0]      r2;
    logic [34:0]      srem;
    logic [31:0]      root;
    logic [63:0]      grem;
    logic [46:0]      gq;
    logic [2:0][31:0] urem;
    logic [2:0][16:0] uq;
    logic             zero;
    logic             capped;
  } mid_t;

  // multiply and saturate stages; each stage fills its own fields
  typedef struct packed {
    logic             valid;
    item_t            it;
    logic             gov;
    logic             rov;
    logic [2:0][47:0] gmag;
    logic signed [47:0] ww;
    logic signed [47:0] qwvx;
    logic signed [47:0] qwvy;
    logic signed [47:0] qphi;
    logic [2:0][31:0] gc;
    logic signed [31:0] w2;
    logic signed [31:0] corx;
    logic signed [31:0] cory;
    logic signed [31:0] sphi;
    logic             sphov;
    logic [2:0][47:0] fq;
    logic [2:0][47:0] vq;
    logic signed [47:0] cxq;
    logic signed [47:0] cyq;
    logic signed [47:0] rcx;
    logic signed [47:0] rcy;
    logic [2:0][31:0] fc;
    logic signed [31:0] vg;
    logic signed [31:0] cenx;
    logic signed [31:0] ceny;
    logic signed [47:0] wq;
    logic signed [47:0] rnx;
    logic signed [47:0] rny;
    logic signed [47:0] vnx;
    logic signed [47:0] vny;
    logic signed [31:0] work;
    logic signed [31:0] vdr;
    logic signed [63:0] mxr;
    logic signed [63:0] myr;
    logic signed [47:0] rvq;
  } late_t;

  // result register
  typedef struct packed {
    logic [31:0] src_mom_x;
    logic [31:0] src_mom_y;
    logic [31:0] src_mom_z;
    logic [31:0] src_energy;
    logic [31:0] src_phi;
    logic [31:0] grav_force_x;
    logic [31:0] grav_force_y;
    logic [31:0] grav_force_z;
    logic [31:0] grav_work;
    logic        grav_valid;
    logic [15:0] out_index;
    logic        overflow;
  } out_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Q16.16 product, truncated toward zero
  function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [63:0] p;
    logic [47:0] m;
    p = {32'd0, mag32(a)} * {32'd0, mag32(b)};
    m = p[63:16];
    qmul = (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] ext48(input logic signed [47:0] v);
    ext48 = {{16{v[47]}}, v};
  endfunction

  function automatic logic signed [63:0] ext32(input logic signed [31:0] v);
    ext32 = {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > QMax) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < QMin) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] v);
    sat_hit = (v > QMax) || (v < QMin);
  endfunction

endpackage

// ----- design/mhd_gravity_rotation_source.sv -----
// A request moves through the front, mid and late stages into the output register.
// Throughput: one request per cycle; a stalled output freezes every stage in place.
// Depth is set by the 32-stage square root followed by the 17-stage unit-vector divide,
// with the 47-stage gravity divide running beside them.
// Reset clears all stage valid bits and loads the register defaults; no clearing pass.
`include "mhd_gravity_rotation_source_assert.svh"

module mhd_gravity_rotation_source import mgrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] density_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] phi_i,
  input  logic [15:0] state_index_i,
  input  logic        perturbed_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] src_mom_x_o,
  output logic signed [31:0] src_mom_y_o,
  output logic signed [31:0] src_mom_z_o,
  output logic signed [31:0] src_energy_o,
  output logic signed [31:0] src_phi_o,
  output logic signed [31:0] grav_force_x_o,
  output logic signed [31:0] grav_force_y_o,
  output logic signed [31:0] grav_force_z_o,
  output logic signed [31:0] grav_work_o,
  output logic        grav_valid_o,
  output logic [15:0] out_index_o,
  output logic        overflow_o
);

  // ---------------- configuration registers ----------------
  logic        gravity_on_q, rotation_on_q, mixed_corr_q, three_d_q;
  logic [30:0] phi_damping_q, gravity_coeff_q;
  logic signed [31:0] omega_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_on_q    <= 1'b0;
      rotation_on_q   <= 1'b1;
      mixed_corr_q    <= 1'b0;
      phi_damping_q   <= '0;
      gravity_coeff_q <= '0;
      omega_q         <= '0;
      three_d_q       <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRAVITY_ON:    gravity_on_q    <= pwdata[0];
        REG_ROTATION_ON:   rotation_on_q   <= pwdata[0];
        REG_MIXED_CORR:    mixed_corr_q    <= pwdata[0];
        REG_PHI_DAMPING:   phi_damping_q   <= pwdata[30:0];
        REG_GRAVITY_COEFF: gravity_coeff_q <= pwdata[30:0];
        REG_OMEGA_RATE:    omega_q         <= pwdata;
        REG_THREE_D:       three_d_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_GRAVITY_ON:    prdata = {31'd0, gravity_on_q};
      REG_ROTATION_ON:   prdata = {31'd0, rotation_on_q};
      REG_MIXED_CORR:    prdata = {31'd0, mixed_corr_q};
      REG_PHI_DAMPING:   prdata = {1'b0, phi_damping_q};
      REG_GRAVITY_COEFF: prdata = {1'b0, gravity_coeff_q};
      REG_OMEGA_RATE:    prdata = omega_q;
      REG_THREE_D:       prdata = {31'd0, three_d_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // whole pipe moves together whenever the output register can take a result
  logic adv;
  logic out_valid_q;
  out_t out_q, out_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- front: capture, squares, radius squared ----------------
  logic  f0_valid_q, f1_valid_q;
  item_t f0_d, f0_q, f1_q;
  logic [2:0][63:0] sq_d, sq_q;
  mid_t  mid_q [0:MidStages];
  mid_t  mid0_d;

  always_comb begin
    f0_d.pos[0] = pos_x_i;
    f0_d.pos[1] = pos_y_i;
    f0_d.pos[2] = three_d_q ? pos_z_i : 32'd0;
    f0_d.vel[0] = vel_x_i;
    f0_d.vel[1] = vel_y_i;
    f0_d.vel[2] = vel_z_i;
    f0_d.rho    = density_i;
    f0_d.phi    = phi_i;
    f0_d.idx    = state_index_i;
    f0_d.pert   = perturbed_i;
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sq_d[l] = {32'd0, mag32(f0_q.pos[l])} * {32'd0, mag32(f0_q.pos[l])};
    end
  end

  always_comb begin
    mid0_d        = '0;
    mid0_d.valid  = f1_valid_q;
    mid0_d.it     = f1_q;
    mid0_d.r2     = sq_q[0] + sq_q[1] + sq_q[2];
    mid0_d.grem   = {48'd0, gravity_coeff_q[30:15]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_valid_q     <= 1'b0;
      f1_valid_q     <= 1'b0;
      mid_q[0].valid <= 1'b0;
    end else if (adv) begin
      f0_valid_q <= in_valid_i;
      f0_q       <= f0_d;
      f1_valid_q <= f0_valid_q;
      f1_q       <= f0_q;
      sq_q       <= sq_d;
      mid_q[0]   <= mid0_d;
    end
  end

  // ---------------- sqrt, gravity divide, unit-vector divide ----------------
  for (genvar k = 0; k < MidStages; k++) begin : g_mid
    mid_t             cur, nxt;
    logic [34:0]      s_rem;
    logic [31:0]      s_root;
    logic [63:0]      g_rem;
    logic [46:0]      g_q;
    logic [2:0][31:0] u_rem;
    logic [2:0][16:0] u_q;
    logic             z_flag, c_flag;

    assign cur = mid_q[k];

    // one root bit per stage, two radicand bits in
    if (k < SqrtSteps) begin : g_sq
      localparam int I = SqrtSteps - 1 - k;
      logic [34:0] sh, tr;
      always_comb begin
        sh = {cur.srem[32:0], cur.r2[2*I+1 -: 2]};
        tr = {1'b0, cur.root, 2'b01};
        if (sh >= tr) begin
          s_rem  = sh - tr;
          s_root = {cur.root[30:0], 1'b1};
        end else begin
          s_rem  = sh;
          s_root = {cur.root[30:0], 1'b0};
        end
      end
    end else begin : g_sq_pass
      assign s_rem  = cur.srem;
      assign s_root = cur.root;
    end

    // restoring divide of gravity_coeff * 2^32 by r2
    if (k < GdivSteps) begin : g_gd
      localparam int J = GdivSteps - 1 - k;
      logic        gbit;
      logic [64:0] sh;
      if (J >= 32) begin : g_kbit
        assign gbit = gravity_coeff_q[J-32];
      end else begin : g_zbit
        assign gbit = 1'b0;
      end
      always_comb begin
        sh = {cur.grem, gbit};
        if (sh >= {1'b0, cur.r2}) begin
          g_rem = 64'(sh - {1'b0, cur.r2});
          g_q   = {cur.gq[45:0], 1'b1};
        end else begin
          g_rem = sh[63:0];
          g_q   = {cur.gq[45:0], 1'b0};
        end
      end
    end else begin : g_gd_pass
      assign g_rem = cur.grem;
      assign g_q   = cur.gq;
    end

    // |p| * 2^16 / r, three lanes
    if (k >= SqrtSteps) begin : g_ud
      localparam int J = MidStages - 1 - k;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [31:0] pm;
        logic [31:0] rin;
        logic        ubit;
        logic [32:0] sh;
        assign pm = mag32(cur.it.pos[l]);
        if (k == SqrtSteps) begin : g_init
          assign rin = {1'b0, pm[31:1]};
        end else begin : g_cont
          assign rin = cur.urem[l];
        end
        if (J == UdivSteps - 1) begin : g_lsb
          assign ubit = pm[0];
        end else begin : g_zero
          assign ubit = 1'b0;
        end
        always_comb begin
          sh = {rin, ubit};
          if (sh >= {1'b0, cur.root}) begin
            u_rem[l] = 32'(sh - {1'b0, cur.root});
            u_q[l]   = {cur.uq[l][15:0], 1'b1};
          end else begin
            u_rem[l] = sh[31:0];
            u_q[l]   = {cur.uq[l][15:0], 1'b0};
          end
        end
      end
    end else begin : g_ud_pass
      assign u_rem = cur.urem;
      assign u_q   = cur.uq;
    end

    // zero radius and magnitude cap, decided once
    if (k == 0) begin : g_flags
      assign z_flag = (cur.r2 == 64'd0);
      assign c_flag = (cur.r2 != 64'd0) && (cur.r2[63:16] == 48'd0) &&
                      ({cur.r2[15:0], 15'd0} <= gravity_coeff_q);
    end else begin : g_flags_pass
      assign z_flag = cur.zero;
      assign c_flag = cur.capped;
    end

    always_comb begin
      nxt        = cur;
      nxt.srem   = s_rem;
      nxt.root   = s_root;
      nxt.grem   = g_rem;
      nxt.gq     = g_q;
      nxt.urem   = u_rem;
      nxt.uq     = u_q;
      nxt.zero   = z_flag;
      nxt.capped = c_flag;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mid_q[k+1].valid <= 1'b0;
      end else if (adv) begin
        mid_q[k+1] <= nxt;
      end
    end
  end

  // ---------------- multiply / saturate stages ----------------
  late_t lt_d [1:LateStages];
  late_t lt_q [1:LateStages];

  // gravity magnitude per axis, rotation and damping products
  always_comb begin
    logic [47:0] gm;
    logic [64:0] prod;
    mid_t        m;
    m        = mid_q[MidStages];
    lt_d[1]  = '0;
    lt_d[1].valid = m.valid;
    lt_d[1].it    = m.it;
    if (m.zero) begin
      gm = '0;
    end else if (m.capped) begin
      gm = GCap;
    end else begin
      gm = {1'b0, m.gq};
    end
    for (int l = 0; l < 3; l++) begin
      prod = {17'd0, gm} * {48'd0, m.uq[l]};
      lt_d[1].gmag[l] = prod[63:16];
    end
    lt_d[1].gov  = m.zero | m.capped;
    lt_d[1].ww   = qmul(omega_q, omega_q);
    lt_d[1].qwvx = qmul(omega_q, m.it.vel[0]);
    lt_d[1].qwvy = qmul(omega_q, m.it.vel[1]);
    lt_d[1].qphi = qmul($signed({1'b0, phi_damping_q}), m.it.phi);
  end

  // signed gravity, W^2, Coriolis, phi damping
  always_comb begin
    logic signed [63:0] v;
    logic signed [63:0] t;
    lt_d[2] = lt_q[1];
    for (int l = 0; l < 3; l++) begin
      v = $signed({16'd0, lt_q[1].gmag[l]});
      if (!lt_q[1].it.pos[l][31]) begin
        v = -v;
      end
      lt_d[2].gc[l] = sat32(v);
      if (sat_hit(v)) lt_d[2].gov = 1'b1;
    end
    t = ext48(lt_q[1].ww);
    lt_d[2].w2 = sat32(t);
    lt_d[2].rov = lt_q[1].rov | sat_hit(t);
    t = -(ext48(lt_q[1].qwvy) <<< 1);
    lt_d[2].corx = sat32(t);
    if (sat_hit(t)) lt_d[2].rov = 1'b1;
    t = ext48(lt_q[1].qwvx) <<< 1;
    lt_d[2].cory = sat32(t);
    if (sat_hit(t)) lt_d[2].rov = 1'b1;
    t = -ext48(lt_q[1].qphi);
    lt_d[2].sphi  = sat32(t);
    lt_d[2].sphov = sat_hit(t);
  end

  // rho*g, v*g, centrifugal and Coriolis products
  always_comb begin
    lt_d[3] = lt_q[2];
    for (int l = 0; l < 3; l++) begin
      lt_d[3].fq[l] = qmul(lt_q[2].it.rho, lt_q[2].gc[l]);
      lt_d[3].vq[l] = qmul(lt_q[2].it.vel[l], lt_q[2].gc[l]);
    end
    lt_d[3].cxq = qmul(lt_q[2].w2, lt_q[2].it.pos[0]);
    lt_d[3].cyq = qmul(lt_q[2].w2, lt_q[2].it.pos[1]);
    lt_d[3].rcx = qmul(lt_q[2].it.rho, lt_q[2].corx);
    lt_d[3].rcy = qmul(lt_q[2].it.rho, lt_q[2].cory);
  end

  // gravity force, V.g, centrifugal acceleration
  always_comb begin
    logic signed [63:0] t;
    lt_d[4] = lt_q[3];
    for (int l = 0; l < 3; l++) begin
      t = ext48(lt_q[3].fq[l]);
      lt_d[4].fc[l] = sat32(t);
      if (sat_hit(t)) lt_d[4].gov = 1'b1;
    end
    t = ext48(lt_q[3].vq[0]) + ext48(lt_q[3].vq[1]) + ext48(lt_q[3].vq[2]);
    lt_d[4].vg = sat32(t);
    if (sat_hit(t)) lt_d[4].gov = 1'b1;
    t = -ext48(lt_q[3].cxq);
    lt_d[4].cenx = sat32(t);
    if (sat_hit(t)) lt_d[4].rov = 1'b1;
    t = -ext48(lt_q[3].cyq);
    lt_d[4].ceny = sat32(t);
    if (sat_hit(t)) lt_d[4].rov = 1'b1;
  end

  // work, centrifugal force and power products
  always_comb begin
    lt_d[5]     = lt_q[4];
    lt_d[5].wq  = qmul(lt_q[4].it.rho, lt_q[4].vg);
    lt_d[5].rnx = qmul(lt_q[4].it.rho, lt_q[4].cenx);
    lt_d[5].rny = qmul(lt_q[4].it.rho, lt_q[4].ceny);
    lt_d[5].vnx = qmul(lt_q[4].it.vel[0], lt_q[4].cenx);
    lt_d[5].vny = qmul(lt_q[4].it.vel[1], lt_q[4].ceny);
  end

  // gravity work, V.cent, rotation momentum terms
  always_comb begin
    logic signed [63:0] t;
    lt_d[6] = lt_q[5];
    t = ext48(lt_q[5].wq);
    lt_d[6].work = sat32(t);
    if (sat_hit(t)) lt_d[6].gov = 1'b1;
    t = ext48(lt_q[5].vnx) + ext48(lt_q[5].vny);
    lt_d[6].vdr = sat32(t);
    if (sat_hit(t)) lt_d[6].rov = 1'b1;
    lt_d[6].mxr = ext48(lt_q[5].rcx) + ext48(lt_q[5].rnx);
    lt_d[6].myr = ext48(lt_q[5].rcy) + ext48(lt_q[5].rny);
  end

  // rotation energy term
  always_comb begin
    lt_d[7]     = lt_q[6];
    lt_d[7].rvq = qmul(lt_q[6].it.rho, lt_q[6].vdr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 1; n <= LateStages; n++) begin
        lt_q[n].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int n = 1; n <= LateStages; n++) begin
        lt_q[n] <= lt_d[n];
      end
    end
  end

  // ---------------- final sums and result register ----------------
  always_comb begin
    logic signed [63:0] mx, my, mz, en;
    logic               ov, gate;
    late_t              s;
    s    = lt_q[LateStages];
    mx   = gravity_on_q ? ext32(s.fc[0]) : 64'sd0;
    my   = gravity_on_q ? ext32(s.fc[1]) : 64'sd0;
    mz   = gravity_on_q ? ext32(s.fc[2]) : 64'sd0;
    en   = gravity_on_q ? ext32(s.work)  : 64'sd0;
    if (rotation_on_q) begin
      mx = mx - s.mxr;
      my = my - s.myr;
      en = en - ext48(s.rvq);
    end
    ov = (gravity_on_q & s.gov) | (rotation_on_q & s.rov) |
         sat_hit(mx) | sat_hit(my) | sat_hit(mz) | sat_hit(en) |
         (mixed_corr_q & s.sphov);
    gate = gravity_on_q & !s.it.pert;
    out_d.src_mom_x    = sat32(mx);
    out_d.src_mom_y    = sat32(my);
    out_d.src_mom_z    = sat32(mz);
    out_d.src_energy   = sat32(en);
    out_d.src_phi      = mixed_corr_q ? s.sphi : 32'd0;
    out_d.grav_force_x = gate ? s.fc[0] : 32'd0;
    out_d.grav_force_y = gate ? s.fc[1] : 32'd0;
    out_d.grav_force_z = gate ? s.fc[2] : 32'd0;
    out_d.grav_work    = gate ? s.work  : 32'd0;
    out_d.grav_valid   = gate;
    out_d.out_index    = s.it.idx;
    out_d.overflow     = ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= lt_q[LateStages].valid;
      out_q       <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign src_mom_x_o    = out_q.src_mom_x;
  assign src_mom_y_o    = out_q.src_mom_y;
  assign src_mom_z_o    = out_q.src_mom_z;
  assign src_energy_o   = out_q.src_energy;
  assign src_phi_o      = out_q.src_phi;
  assign grav_force_x_o = out_q.grav_force_x;
  assign grav_force_y_o = out_q.grav_force_y;
  assign grav_force_z_o = out_q.grav_force_z;
  assign grav_work_o    = out_q.grav_work;
  assign grav_valid_o   = out_q.grav_valid;
  assign out_index_o    = out_q.out_index;
  assign overflow_o     = out_q.overflow;

  // ---------------- checks ----------------
  `MGRS_ASSERT_IMP(a_grav_valid_on, clk_i, rst_ni, out_valid_q && out_q.grav_valid, gravity_on_q, "gravity result flagged while gravity is off")
  `MGRS_ASSERT_IMP(a_phi_hyperbolic, clk_i, rst_ni, out_valid_q && !mixed_corr_q, out_q.src_phi == 32'd0, "phi damping present in hyperbolic mode")
  `MGRS_ASSERT_NXT(a_stall_freeze, clk_i, rst_ni, !adv, $stable(lt_q[LateStages]) && $stable(mid_q[MidStages]), "pipeline moved during a stall")
  `MGRS_ASSERT_NXT(a_last_to_out, clk_i, rst_ni, adv && lt_q[LateStages].valid, out_valid_q, "result lost between last stage and output")

endmodule

// ----- tb/tb_mhd_gravity_rotation_source.sv -----
// Self-checking testbench for the gravity and rotation source block
module tb_mhd_gravity_rotation_source import mgrs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 59;
  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, density_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0, phi_i = '0;
  logic [15:0] state_index_i = '0;
  logic perturbed_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] src_mom_x_o, src_mom_y_o, src_mom_z_o, src_energy_o, src_phi_o;
  logic signed [31:0] grav_force_x_o, grav_force_y_o, grav_force_z_o, grav_work_o;
  logic grav_valid_o;
  logic [15:0] out_index_o;
  logic overflow_o;

  mhd_gravity_rotation_source dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one solution point
  typedef struct {
    logic signed [31:0] px, py, pz, rho, vx, vy, vz, phi;
    logic [15:0] idx;
    logic pert;
  } point_t;

  // predicted register copy
  logic cfg_grav, cfg_rot, cfg_mixed, cfg_3d;
  logic [30:0] cfg_damp, cfg_gcoef;
  logic signed [31:0] cfg_omega;

  out_t sources_q[$];
  int mismatches = 0;
  int accepted_points = 0;
  int checked_points = 0;
  bit out_idle_en = 1'b1;
  bit in_idle_en = 1'b1;
  int quiet_cycles = 0;

  function automatic longint q_mul(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_q(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // expected sources for one point under the current register copy
  function automatic out_t point_sources(point_t pt);
    longint p[3], g[3], rho, vx, vy, vz;
    longint mx, my, mz, en, sphi, fx, fy, fz, work;
    longint w, w2, corx, cory, cenx, ceny, vdr;
    longint unsigned r2, r, gm, u, m;
    bit gov, rov, ov;
    out_t o;
    gov = 1'b0; rov = 1'b0; ov = 1'b0;
    mx = 0; my = 0; mz = 0; en = 0; sphi = 0;
    g[0] = 0; g[1] = 0; g[2] = 0;
    p[0] = pt.px; p[1] = pt.py; p[2] = cfg_3d ? longint'(pt.pz) : 0;
    rho = pt.rho; vx = pt.vx; vy = pt.vy; vz = pt.vz;
    r2 = 0;
    for (int i = 0; i < 3; i++) begin
      m = (p[i] < 0) ? -p[i] : p[i];
      r2 += m * m;
    end
    if (r2 == 0) begin
      gov = 1'b1;
    end else begin
      r = int_root(r2);
      gm = ({33'd0, cfg_gcoef} << 32) / r2;
      if (gm >= (64'd1 << 47)) begin
        gm = 64'd1 << 47;
        gov = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        m = (p[i] < 0) ? -p[i] : p[i];
        u = (m << 16) / r;
        m = (gm * u) >> 16;
        g[i] = clamp_q((p[i] < 0) ? longint'(m) : -longint'(m), gov);
      end
    end
    fx = clamp_q(q_mul(rho, g[0]), gov);
    fy = clamp_q(q_mul(rho, g[1]), gov);
    fz = clamp_q(q_mul(rho, g[2]), gov);
    work = clamp_q(q_mul(rho, clamp_q(q_mul(vx, g[0]) + q_mul(vy, g[1]) + q_mul(vz, g[2]),
                                      gov)), gov);
    if (cfg_grav) begin
      mx = fx; my = fy; mz = fz; en = work;
      if (gov) ov = 1'b1;
    end
    if (cfg_rot) begin
      w = cfg_omega;
      w2 = clamp_q(q_mul(w, w), rov);
      corx = clamp_q(-2 * q_mul(w, vy), rov);
      cory = clamp_q(2 * q_mul(w, vx), rov);
      cenx = clamp_q(-q_mul(w2, p[0]), rov);
      ceny = clamp_q(-q_mul(w2, p[1]), rov);
      vdr = clamp_q(q_mul(vx, cenx) + q_mul(vy, ceny), rov);
      mx = mx - (q_mul(rho, corx) + q_mul(rho, cenx));
      my = my - (q_mul(rho, cory) + q_mul(rho, ceny));
      en = en - q_mul(rho, vdr);
      if (rov) ov = 1'b1;
    end
    mx = clamp_q(mx, ov); my = clamp_q(my, ov);
    mz = clamp_q(mz, ov); en = clamp_q(en, ov);
    if (cfg_mixed) sphi = clamp_q(-q_mul(longint'(cfg_damp), pt.phi), ov);
    o = '0;
    o.src_mom_x = mx[31:0]; o.src_mom_y = my[31:0]; o.src_mom_z = mz[31:0];
    o.src_energy = en[31:0]; o.src_phi = sphi[31:0];
    if (cfg_grav && !pt.pert) begin
      o.grav_force_x = fx[31:0]; o.grav_force_y = fy[31:0];
      o.grav_force_z = fz[31:0]; o.grav_work = work[31:0];
      o.grav_valid = 1'b1;
    end
    o.out_index = pt.idx;
    o.overflow = ov;
    return o;
  endfunction

  // result side: random stalls and the field-by-field compare
  int stall_left = 0;
  always @(posedge clk_i) begin
    out_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{src_mom_x_o, src_mom_y_o, src_mom_z_o, src_energy_o, src_phi_o,
                grav_force_x_o, grav_force_y_o, grav_force_z_o, grav_work_o,
                grav_valid_o, out_index_o, overflow_o};
        checked_points++;
        if (sources_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, index %0d", out_index_o);
        end else begin
          want = sources_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch idx %0d: exp mom %h %h %h en %h phi %h", want.out_index,
                       want.src_mom_x, want.src_mom_y, want.src_mom_z, want.src_energy,
                       want.src_phi);
              $display("  got mom %h %h %h en %h phi %h", got.src_mom_x, got.src_mom_y,
                       got.src_mom_z, got.src_energy, got.src_phi);
              $display("  exp grav %h %h %h %h v%b i%0d ov%b", want.grav_force_x,
                       want.grav_force_y, want.grav_force_z, want.grav_work,
                       want.grav_valid, want.out_index, want.overflow);
              $display("  got grav %h %h %h %h v%b i%0d ov%b", got.grav_force_x,
                       got.grav_force_y, got.grav_force_z, got.grav_work,
                       got.grav_valid, got.out_index, got.overflow);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= (stall_left == 0);
      end else if (out_idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("mhd_gravity_rotation_source test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // setup then access; select stays up between back-to-back writes
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_GRAVITY_ON: cfg_grav = val[0];
      REG_ROTATION_ON: cfg_rot = val[0];
      REG_MIXED_CORR: cfg_mixed = val[0];
      REG_PHI_DAMPING: cfg_damp = val[30:0];
      REG_GRAVITY_COEFF: cfg_gcoef = val[30:0];
      REG_OMEGA_RATE: cfg_omega = val;
      REG_THREE_D: cfg_3d = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic g, logic rot, logic mix, logic [30:0] damp,
                         logic [30:0] k, logic [31:0] w, logic d3);
    write_reg(REG_GRAVITY_ON, {31'd0, g});
    write_reg(REG_ROTATION_ON, {31'd0, rot});
    write_reg(REG_MIXED_CORR, {31'd0, mix});
    write_reg(REG_PHI_DAMPING, {1'b0, damp});
    write_reg(REG_GRAVITY_COEFF, {1'b0, k});
    write_reg(REG_OMEGA_RATE, w);
    write_reg(REG_THREE_D, {31'd0, d3});
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until every expected result is back, then let the pipe drain
  task automatic drain_sources();
    in_valid_i <= 1'b0;
    while (sources_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // valid stays up after an accept; it drops only for idling or draining
  task automatic send_point(point_t pt);
    if (in_idle_en && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= pt.px; pos_y_i <= pt.py; pos_z_i <= pt.pz; density_i <= pt.rho;
    vel_x_i <= pt.vx; vel_y_i <= pt.vy; vel_z_i <= pt.vz; phi_i <= pt.phi;
    state_index_i <= pt.idx; perturbed_i <= pt.pert;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sources_q = {sources_q, point_sources(pt)};
    accepted_points++;
  endtask

  // a value spread over magnitudes, occasionally at the extremes
  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 255)) - 128) <<< 16;
      default: return $signed($urandom()) >>> $urandom_range(4, 28);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    pt.px = rand_q(); pt.py = rand_q(); pt.pz = rand_q(); pt.rho = rand_q();
    pt.vx = rand_q(); pt.vy = rand_q(); pt.vz = rand_q(); pt.phi = rand_q();
    if ($urandom_range(0, 19) == 0) begin
      pt.px = 0; pt.py = 0; pt.pz = 0;
    end
    pt.idx = 16'($urandom());
    pt.pert = 1'($urandom_range(0, 1));
    return pt;
  endfunction

  // directed points: zero radius, extremes, perturbed, every enable
  task automatic test_directed();
    point_t pt;
    logic [31:0] ex[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF};
    set_all(1'b1, 1'b1, 1'b1, 31'h0001_8000, 31'h0002_0000, 32'h0000_4000, 1'b1);
    for (int i = 0; i < 8; i++) begin
      pt.px = ex[i % 4]; pt.py = ex[(i + 1) % 4]; pt.pz = ex[(i + 2) % 4];
      pt.rho = ex[(i + 3) % 4]; pt.vx = ex[i % 4]; pt.vy = ex[(i + 2) % 4];
      pt.vz = ex[(i + 1) % 4]; pt.phi = ex[(i + 3) % 4];
      pt.idx = (i % 2) ? 16'hFFFF : 16'h0000; pt.pert = i[0];
      send_point(pt);
    end
    pt = '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 16'd7, 1'b0};
    send_point(pt);
    pt.px = 32'h0000_0001; pt.pz = 32'h7FFF_0000;
    send_point(pt);
    drain_sources();
    set_all(1'b1, 1'b0, 1'b0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    for (int i = 0; i < 6; i++) send_point(rand_point());
    drain_sources();
    set_all(1'b0, 1'b1, 1'b1, 31'h7FFF_FFFF, 31'h0, 32'h7FFF_FFFF, 1'b1);
    for (int i = 0; i < 6; i++) send_point(rand_point());
    drain_sources();
  endtask

  // random phases, each under its own register setting
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 3) == 0 ? 31'h7FFF_FFFF : 31'($urandom() >> $urandom_range(1, 16)),
              $urandom_range(0, 3) == 0 ? 31'h7FFF_FFFF : 31'($urandom() >> $urandom_range(1, 24)),
              rand_q(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < per_phase; i++) send_point(rand_point());
      drain_sources();
    end
  endtask

  // final stretch at full rate on both sides
  task automatic test_full_rate();
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    test_random(2, 100);
  endtask

  initial begin
    cfg_grav = 0; cfg_rot = 1; cfg_mixed = 0; cfg_damp = 0;
    cfg_gcoef = 0; cfg_omega = 0; cfg_3d = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset defaults first
    for (int i = 0; i < 4; i++) send_point(rand_point());
    drain_sources();
    test_directed();
    test_random(10, 100);
    test_full_rate();
    $display("covered %0d points (%0d results checked) over 16 register settings",
             accepted_points, checked_points);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && sources_q.size() == 0) begin
      $display("mhd_gravity_rotation_source test passed");
    end else begin
      $display("mhd_gravity_rotation_source test failed");
    end
    $finish;
  end

endmodule
